@@ rtl/cstrip_pkg.sv @@
`default_nettype none

package cstrip_pkg;

  // Marker characters.
  localparam logic [7:0] CharHash    = 8'h23;  // '#'
  localparam logic [7:0] CharAt      = 8'h40;  // '@'
  localparam logic [7:0] CharPercent = 8'h25;  // '%'
  localparam logic [7:0] CharNewline = 8'h0A;  // '\n'

  // Input item kinds, carried on the slave tuser.
  localparam logic KindText = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Positions consumed by each marker after its first byte.
  localparam logic [1:0] SkipLineOpen  = 2'd2;
  localparam logic [1:0] SkipBlockMark = 2'd1;

  // Output queue geometry.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic       in_line;
    logic       in_block;
    logic [1:0] skip;
  } mode_t;

  typedef struct packed {
    logic  keep;
    mode_t mode;
  } decision_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // Decides one position w0 given up to two bytes of lookahead.
  function automatic decision_t decide(input mode_t m, input logic [7:0] w0,
                                       input logic v1, input logic [7:0] w1,
                                       input logic v2, input logic [7:0] w2);
    decision_t d;
    d.keep = 1'b0;
    d.mode = m;
    if (m.skip != 2'd0) begin
      d.mode.skip = m.skip - 2'd1;
    end else if (w0 == CharHash && v1 && w1 == CharHash && v2 && w2 == CharHash) begin
      d.mode.in_line = 1'b1;
      d.mode.skip    = SkipLineOpen;
    end else if (w0 == CharAt && v1 && w1 == CharPercent) begin
      d.mode.in_block = 1'b1;
      d.mode.skip     = SkipBlockMark;
    end else if (m.in_line && w0 == CharNewline) begin
      d.mode.in_line = 1'b0;
    end else if (m.in_block && w0 == CharPercent && v1 && w1 == CharAt) begin
      d.mode.in_block = 1'b0;
      d.mode.skip     = SkipBlockMark;
    end else if (!m.in_line && !m.in_block) begin
      d.keep = 1'b1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cstrip_out_fifo.sv @@
`default_nettype none

// Small result queue: takes up to two results per cycle, hands out one.
module cstrip_out_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [1:0]          push_cnt_i,
  input  wire cstrip_pkg::result_t push_data0_i,
  input  wire cstrip_pkg::result_t push_data1_i,
  output logic                     space_o,
  output logic                     valid_o,
  output cstrip_pkg::result_t      data_o,
  input  wire logic                pop_i
);
  import cstrip_pkg::*;

  result_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;
  logic                  do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  // Room for a worst-case push of two results.
  assign space_o = (count_q <= QueueCntW'(QueueDepth - 2));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QueuePtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + QueuePtrW'(do_pop);
    count_d  = count_q + QueueCntW'(push_cnt_i) - QueueCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + QueuePtrW'(1)] <= push_data1_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/comment_stripper_core.sv @@
`default_nettype none

// Streaming comment remover. Text arrives one byte per transfer on the slave
// side (tuser low) and only bytes outside comments leave on the master side.
// "###" opens a line comment that a newline closes, "@%" opens a block comment
// that "%@" closes, and marker bytes are never passed on. Each byte is decided
// with a lookahead of the two bytes after it, so the first result of a text
// appears only once three bytes or an end transfer have arrived, and the last
// two bytes stay held until an end transfer (tuser high) arrives. The end
// transfer decides the held bytes, emits them (at most two results) with tlast
// on the final one, or a single empty result (tuser low, tdata zero) with
// tlast if nothing is kept, and returns the block to its reset state. The
// block takes one transfer per clock cycle; results are registered in a
// four-entry output queue and wait there until the master side takes them;
// the slave side stalls only while three or more results are waiting, which
// is what bounds throughput when the downstream side applies back-pressure.
module comment_stripper_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Slave side
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic       s_axis_tuser_i,   // [0] kind (0 text byte, 1 end of text)
  // Master side
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tuser_o,   // [0] has_byte
  output logic            m_axis_tlast_o    // last
);
  import cstrip_pkg::*;

  // Comment flags and count of marker positions still to be consumed.
  mode_t       mode_q, mode_d;
  // Held bytes waiting for their lookahead; valid below held_cnt_q.
  logic [7:0]  held_q [2];
  logic [7:0]  held_d [2];
  logic [1:0]  held_cnt_q, held_cnt_d;

  logic        accept;
  logic        fifo_space;
  logic [1:0]  push_cnt;
  result_t     res0, res1;
  result_t     head;

  decision_t   dec_step;   // steady-state decision of the oldest held byte
  decision_t   dec_end0;   // end of text, first held byte
  decision_t   dec_end1;   // end of text, second held byte
  logic        two_held;
  logic        keep0, keep1;

  assign s_axis_tready_o = fifo_space;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign two_held        = (held_cnt_q == 2'd2);

  // With two bytes held, the incoming byte completes the window of the oldest.
  assign dec_step = decide(mode_q, held_q[0], 1'b1, held_q[1], 1'b1, s_axis_tdata_i);

  // At the end of text, bytes past the end never match a marker. The second
  // decision sees the mode that the first one leaves behind.
  assign dec_end0 = decide(mode_q, held_q[0], two_held,
                           two_held ? held_q[1] : 8'h00, 1'b0, 8'h00);
  assign dec_end1 = decide(dec_end0.mode, held_q[1], 1'b0, 8'h00, 1'b0, 8'h00);
  assign keep0    = (held_cnt_q != 2'd0) && dec_end0.keep;
  assign keep1    = two_held && dec_end1.keep;

  always_comb begin
    mode_d     = mode_q;
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    push_cnt   = 2'd0;
    res0       = '0;
    res1       = '0;
    if (accept) begin
      if (s_axis_tuser_i == KindText) begin
        if (!two_held) begin
          // Still filling the lookahead window.
          held_d[held_cnt_q[0]] = s_axis_tdata_i;
          held_cnt_d            = held_cnt_q + 2'd1;
        end else begin
          mode_d    = dec_step.mode;
          held_d[0] = held_q[1];
          held_d[1] = s_axis_tdata_i;
          if (dec_step.keep) begin
            push_cnt = 2'd1;
            res0     = '{has_byte: 1'b1, out_byte: held_q[0], last: 1'b0};
          end
        end
      end else begin
        // End of text: flush what is held, then start over.
        mode_d     = '0;
        held_cnt_d = 2'd0;
        if (keep0 && keep1) begin
          push_cnt = 2'd2;
          res0     = '{has_byte: 1'b1, out_byte: held_q[0], last: 1'b0};
          res1     = '{has_byte: 1'b1, out_byte: held_q[1], last: 1'b1};
        end else if (keep0) begin
          push_cnt = 2'd1;
          res0     = '{has_byte: 1'b1, out_byte: held_q[0], last: 1'b1};
        end else if (keep1) begin
          push_cnt = 2'd1;
          res0     = '{has_byte: 1'b1, out_byte: held_q[1], last: 1'b1};
        end else begin
          push_cnt = 2'd1;
          res0     = '{has_byte: 1'b0, out_byte: 8'h00, last: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      held_cnt_q <= 2'd0;
    end else begin
      mode_q     <= mode_d;
      held_cnt_q <= held_cnt_d;
    end
  end

  // Held bytes carry no reset; only entries below the count are ever used.
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  cstrip_out_fifo u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cnt_i   (push_cnt),
    .push_data0_i (res0),
    .push_data1_i (res1),
    .space_o      (fifo_space),
    .valid_o      (m_axis_tvalid_o),
    .data_o       (head),
    .pop_i        (m_axis_tready_i)
  );

  assign m_axis_tdata_o = head.out_byte;
  assign m_axis_tuser_o = head.has_byte;
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire

@@ rtl/cstrip_checker.sv @@
`default_nettype none

// Port-level checks for the comment stripper.
module cstrip_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       s_axis_tuser_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // An empty result only closes a text, and carries a zero byte.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o == 8'h00)
    else $error("empty result without tlast or with data");

  // The input only stalls while results are backed up.
  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  // After an end transfer, a result is always waiting in the next cycle.
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> m_axis_tvalid_o)
    else $error("end of text produced no result");

endmodule

bind comment_stripper_core cstrip_checker u_cstrip_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
